### rtl/core/seam_linear_blend_defines.svh
// ============================================================================
// Seam linear blend: assertion macros
// Shared assertion forms for the checker of the seam blender.
// ============================================================================
`ifndef SEAM_LINEAR_BLEND_DEFINES_SVH
`define SEAM_LINEAR_BLEND_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/slb_pkg.sv
// ============================================================================
// Seam linear blend package
// Widths, register indexes, stage payload types and the divider step.
// ============================================================================
package slb_pkg;

    // Field widths.
    localparam int COL_W      = 13;
    localparam int START_W    = 13;
    localparam int WIDTH_W    = 14;
    localparam int PIX_W      = 8;
    localparam int NUM_CH     = 3;
    localparam int MAX_WIDTH  = 8192;

    // Blend numerator and quotient.
    localparam int NUM_W      = PIX_W + WIDTH_W;
    localparam int QUOT_W     = PIX_W;
    localparam int BIT_IDX_W  = $clog2(QUOT_W);

    // Stream and configuration port widths.
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_WIDTH    = 1'b1;

    // Reset values.
    localparam logic [START_W-1:0] OVERLAP_START_RST = '0;
    localparam logic [WIDTH_W-1:0] BASE_WIDTH_RST    = 14'd1024;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH_VAL     = WIDTH_W'(MAX_WIDTH);

    // One RGB pixel, red in the lowest bits.
    typedef logic [NUM_CH-1:0][PIX_W-1:0] pixel_t;
    typedef logic [NUM_CH-1:0][NUM_W-1:0] wide_t;

    // Decode stage payload.
    typedef struct packed {
        logic                blend;
        pixel_t              pix;
        pixel_t              base;
        pixel_t              warped;
        logic [WIDTH_W-1:0]  wid;
        logic [COL_W-1:0]    k;
        logic [WIDTH_W-1:0]  wmk;
    } dec_t;

    // Product stage payload.
    typedef struct packed {
        logic                blend;
        pixel_t              pix;
        logic [WIDTH_W-1:0]  wid;
        wide_t               pb;
        wide_t               pw;
    } prod_t;

    // Divider payload: pix holds the copied pixel or the quotient being built.
    typedef struct packed {
        logic                blend;
        pixel_t              pix;
        logic [WIDTH_W-1:0]  wid;
        wide_t               rem;
    } div_t;

    // One restoring division step producing quotient bit bit_pos per channel.
    function automatic div_t div_step(input div_t d, input logic [BIT_IDX_W-1:0] bit_pos);
        div_t             r;
        logic [NUM_W-1:0] cand;
        r    = d;
        cand = NUM_W'(d.wid) << bit_pos;
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (d.blend && (d.rem[c] >= cand))
            begin
                r.rem[c]          = d.rem[c] - cand;
                r.pix[c][bit_pos] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

### rtl/core/slb_decode.sv
// ============================================================================
// Seam blend decode stage
// Classifies the column against the overlap and prepares blend weights.
// ============================================================================
module slb_decode (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [slb_pkg::START_W-1:0]   overlap_start,
    input  logic [slb_pkg::WIDTH_W-1:0]   base_width,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [slb_pkg::COL_W-1:0]     column,
    input  slb_pkg::pixel_t               base,
    input  slb_pkg::pixel_t               warped,
    output logic                          out_valid,
    input  logic                          out_ready,
    output slb_pkg::dec_t                 out_data
);

    logic                          vld_reg;
    slb_pkg::dec_t                 data_reg;
    slb_pkg::dec_t                 data_next;
    logic                          en;
    logic [slb_pkg::WIDTH_W-1:0]   bw_sat;
    logic [slb_pkg::WIDTH_W-1:0]   col_ext;
    logic [slb_pkg::WIDTH_W-1:0]   start_ext;
    logic                          warp_zero;

    // Stage advances when empty or when the next stage takes its content.
    assign en       = !vld_reg || out_ready;
    assign in_ready = en;

    // Decision: warped copy, base copy, or weighted blend.
    always_comb
    begin
        bw_sat    = (base_width > slb_pkg::MAX_WIDTH_VAL) ? slb_pkg::MAX_WIDTH_VAL : base_width;
        col_ext   = slb_pkg::WIDTH_W'(column);
        start_ext = slb_pkg::WIDTH_W'(overlap_start);
        warp_zero = (warped == '0);

        data_next.base   = base;
        data_next.warped = warped;
        data_next.wid    = bw_sat - start_ext;
        data_next.k      = column - overlap_start;
        data_next.wmk    = data_next.wid - slb_pkg::WIDTH_W'(data_next.k);
        data_next.blend  = 1'b0;
        data_next.pix    = base;

        if (col_ext >= bw_sat)
        begin
            data_next.pix = warped;
        end
        else if ((column >= overlap_start) && !warp_zero)
        begin
            data_next.blend = (col_ext > data_next.wid);
        end
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_valid;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

### rtl/core/slb_mix.sv
// ============================================================================
// Seam blend weighting stages
// Multiplies each channel by its weight, then sums into the numerator.
// ============================================================================
module slb_mix (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  slb_pkg::dec_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output slb_pkg::div_t   out_data
);

    logic            prod_vld_reg;
    slb_pkg::prod_t  prod_reg;
    slb_pkg::prod_t  prod_next;
    logic            sum_vld_reg;
    slb_pkg::div_t   sum_reg;
    slb_pkg::div_t   sum_next;
    logic            prod_en;
    logic            sum_en;

    // Ready chain from the output back to the input.
    assign sum_en   = !sum_vld_reg || out_ready;
    assign prod_en  = !prod_vld_reg || sum_en;
    assign in_ready = prod_en;

    // Products: base by (W - k) and warped by k.
    always_comb
    begin
        prod_next.blend = in_data.blend;
        prod_next.pix   = in_data.pix;
        prod_next.wid   = in_data.wid;
        for (int c = 0; c < slb_pkg::NUM_CH; c++)
        begin
            prod_next.pb[c] = slb_pkg::NUM_W'(in_data.base[c] * in_data.wmk);
            prod_next.pw[c] = slb_pkg::NUM_W'(in_data.warped[c] * in_data.k);
        end
    end

    // Numerator sum; the quotient is built in pix, so clear it for blends.
    always_comb
    begin
        sum_next.blend = prod_reg.blend;
        sum_next.pix   = prod_reg.blend ? '0 : prod_reg.pix;
        sum_next.wid   = prod_reg.wid;
        for (int c = 0; c < slb_pkg::NUM_CH; c++)
        begin
            sum_next.rem[c] = prod_reg.pb[c] + prod_reg.pw[c];
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            sum_vld_reg  <= 1'b0;
        end
        else
        begin
            if (prod_en)
            begin
                prod_vld_reg <= in_valid;
            end
            if (sum_en)
            begin
                sum_vld_reg <= prod_vld_reg;
            end
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (prod_en && in_valid)
        begin
            prod_reg <= prod_next;
        end
        if (sum_en && prod_vld_reg)
        begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = sum_vld_reg;
    assign out_data  = sum_reg;

endmodule

### rtl/core/slb_div.sv
// ============================================================================
// Seam blend divider
// Pipelined restoring divider, one quotient bit per stage for all channels.
// ============================================================================
module slb_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  slb_pkg::div_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output slb_pkg::div_t   out_data
);

    localparam int NSTG = slb_pkg::QUOT_W;

    logic [NSTG-1:0]   vld_reg;
    slb_pkg::div_t     stg_reg  [NSTG];
    slb_pkg::div_t     stg_in   [NSTG];
    slb_pkg::div_t     stg_next [NSTG];
    logic [NSTG-1:0]   vld_in;
    logic [NSTG-1:0]   en;
    logic [NSTG:0]     rdy_chain;

    // Ready chain: a stage moves when empty or when its successor moves.
    always_comb
    begin
        rdy_chain[NSTG] = out_ready;
        for (int s = NSTG - 1; s >= 0; s--)
        begin
            en[s]        = !vld_reg[s] || rdy_chain[s + 1];
            rdy_chain[s] = en[s];
        end
    end

    // Stage inputs and one quotient bit per stage, most significant first.
    always_comb
    begin
        for (int s = 0; s < NSTG; s++)
        begin
            if (s == 0)
            begin
                stg_in[s] = in_data;
                vld_in[s] = in_valid;
            end
            else
            begin
                stg_in[s] = stg_reg[s - 1];
                vld_in[s] = vld_reg[s - 1];
            end
            stg_next[s] = slb_pkg::div_step(stg_in[s], slb_pkg::BIT_IDX_W'(NSTG - 1 - s));
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < NSTG; s++)
            begin
                if (en[s])
                begin
                    vld_reg[s] <= vld_in[s];
                end
            end
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NSTG; s++)
        begin
            if (en[s] && vld_in[s])
            begin
                stg_reg[s] <= stg_next[s];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NSTG-1];
    assign out_data  = stg_reg[NSTG-1];

endmodule

### rtl/core/seam_linear_blend.sv
// ============================================================================
// Seam linear blend
// Feather blending of a base and a warped RGB image across a stitching seam.
// ============================================================================
// Usage:
//   The s_axis channel takes one pixel per transfer: the output column and
//   the base and warped RGB pixels at that column. The m_axis channel gives
//   one stitched pixel per input transfer, in order, with tuser set when the
//   weighted blend was applied rather than a source pixel copied.
//   The cfg channel writes overlap_start (index 0) and base_width (index 1);
//   it is always ready and must only be used while no pixel is in flight.
//   A pixel passes from input transfer to output valid through eleven
//   register stages: one decode stage, a multiply and a sum stage, and eight
//   divider stages producing one quotient bit each. Throughput is one pixel
//   per clock while the receiver does not stall.
//   Every stage has its own valid bit; when the receiver stalls, the output
//   holds and the stages behind it keep filling until all are occupied, and
//   only then does s_axis_tready fall. Nothing is lost or repeated.
//   Reset clears all valid bits and loads overlap_start = 0 and
//   base_width = 1024.
// ============================================================================
module seam_linear_blend (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [slb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [slb_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input pixels.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // column, base_red, base_green, base_blue, warped_red, warped_green,
    // warped_blue, zero fill
    input  logic [slb_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // Output pixels.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_red, out_green, out_blue
    output logic [slb_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // was_blended
    output logic                               m_axis_tuser
);

    localparam int PIX_BITS = slb_pkg::NUM_CH * slb_pkg::PIX_W;

    logic [slb_pkg::START_W-1:0]  overlap_start_reg;
    logic [slb_pkg::WIDTH_W-1:0]  base_width_reg;
    logic [slb_pkg::COL_W-1:0]    in_column;
    slb_pkg::pixel_t              in_base;
    slb_pkg::pixel_t              in_warped;
    logic                         dec_valid;
    logic                         dec_ready;
    slb_pkg::dec_t                dec_data;
    logic                         mix_valid;
    logic                         mix_ready;
    slb_pkg::div_t                mix_data;
    slb_pkg::div_t                div_data;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlap_start_reg <= slb_pkg::OVERLAP_START_RST;
            base_width_reg    <= slb_pkg::BASE_WIDTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                slb_pkg::REG_OVERLAP_START:
                begin
                    overlap_start_reg <= cfg_data[slb_pkg::START_W-1:0];
                end
                slb_pkg::REG_BASE_WIDTH:
                begin
                    base_width_reg <= cfg_data[slb_pkg::WIDTH_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Unpack the input transfer.
    assign in_column = s_axis_tdata[slb_pkg::COL_W-1:0];
    assign in_base   = s_axis_tdata[slb_pkg::COL_W +: PIX_BITS];
    assign in_warped = s_axis_tdata[slb_pkg::COL_W + PIX_BITS +: PIX_BITS];

    slb_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .overlap_start (overlap_start_reg),
        .base_width    (base_width_reg),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .column        (in_column),
        .base          (in_base),
        .warped        (in_warped),
        .out_valid     (dec_valid),
        .out_ready     (dec_ready),
        .out_data      (dec_data)
    );

    slb_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (mix_valid),
        .out_ready (mix_ready),
        .out_data  (mix_data)
    );

    slb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mix_valid),
        .in_ready  (mix_ready),
        .in_data   (mix_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (div_data)
    );

    // Pack the output transfer.
    assign m_axis_tdata = div_data.pix;
    assign m_axis_tuser = div_data.blend;

endmodule

### rtl/core/slb_checker.sv
// ============================================================================
// Seam blend port checker
// Watches the top-level ports for flow-control and output-hold rules.
// ============================================================================
`include "seam_linear_blend_defines.svh"

module slb_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [slb_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input  logic                               m_axis_tuser
);

    // Configuration writes are never held off.
    `SLB_ASSERT_SAME(a_cfg_always_ready, clk, rst_n, cfg_valid, cfg_ready, "cfg write refused")

    // An empty or draining output stage must let the pipeline take a pixel.
    `SLB_ASSERT_SAME(a_input_not_blocked, clk, rst_n, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input stalled with free output")

    // A stalled result stays valid and unchanged.
    `SLB_ASSERT_NEXT(a_output_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output changed")

endmodule

bind seam_linear_blend slb_checker u_slb_checker (.*);

### tb/sv/seam_linear_blend_check.sv
// ============================================================================
// Seam linear blend checker
// Watches the configuration, pixel input and pixel output channels, predicts
// every stitched pixel from its own copy of the blend window and compares
// each output transfer, field by field, with the oldest prediction.
// ============================================================================
`timescale 1ns / 100ps

module seam_linear_blend_check
    import slb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Configuration write channel.
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    // Input pixels.
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    // column, base_red, base_green, base_blue, warped_red, warped_green,
    // warped_blue, zero fill
    input  logic [S_TDATA_W-1:0]    s_axis_tdata,
    // Output pixels.
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // out_red, out_green, out_blue
    input  logic [M_TDATA_W-1:0]    m_axis_tdata,
    // was_blended
    input  logic                    m_axis_tuser,
    // Totals handed to the testbench top.
    output int                      mismatch_count,
    output int                      pending_count
);

    // One stitched pixel as seen on the output channel.
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             blended;
    } stitched_t;

    stitched_t           expected_pixels[$];
    logic [START_W-1:0]  window_start = OVERLAP_START_RST;
    logic [WIDTH_W-1:0]  window_width = BASE_WIDTH_RST;
    int                  failures     = 0;

    // Print one line per mismatch and count every one.
    task automatic report_mismatch(input string what);
        $display("[%0t] stitch mismatch: %s", $time, what);
        failures++;
    endtask

    // Work out the stitched pixel for one input transfer under the current window.
    function automatic stitched_t stitch_pixel(input logic [S_TDATA_W-1:0] beat);
        stitched_t   res;
        pixel_t      base;
        pixel_t      warped;
        pixel_t      pick;
        logic        blend;
        int unsigned col;
        int unsigned limit;
        int unsigned span;
        int unsigned offs;
        col    = beat[COL_W-1:0];
        base   = beat[COL_W +: NUM_CH*PIX_W];
        warped = beat[COL_W + NUM_CH*PIX_W +: NUM_CH*PIX_W];
        limit  = (window_width > MAX_WIDTH) ? MAX_WIDTH : window_width;
        blend  = 1'b0;
        pick   = base;
        // The width test comes first; past it the warped image takes over.
        if (col >= limit)
        begin
            pick = warped;
        end
        else if (col >= window_start && warped != '0)
        begin
            span = limit - window_start;
            offs = col - window_start;
            // The blend only applies where the column exceeds the overlap width.
            if (col > span)
            begin
                blend = 1'b1;
                for (int c = 0; c < NUM_CH; c++)
                begin
                    pick[c] = PIX_W'((base[c] * (span - offs) + warped[c] * offs) / span);
                end
            end
        end
        res.red     = pick[0];
        res.green   = pick[1];
        res.blue    = pick[2];
        res.blended = blend;
        return res;
    endfunction

    // Track the window, queue predictions and compare results.
    always @(posedge clk)
    begin
        stitched_t want;
        stitched_t got;
        if (!rst_n)
        begin
            window_start = OVERLAP_START_RST;
            window_width = BASE_WIDTH_RST;
            expected_pixels.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_OVERLAP_START: window_start = cfg_data[START_W-1:0];
                    REG_BASE_WIDTH:    window_width = cfg_data[WIDTH_W-1:0];
                    default:           ;
                endcase
            end
            // Results leave before new pixels join, so the oldest is compared.
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.red     = m_axis_tdata[PIX_W-1:0];
                got.green   = m_axis_tdata[2*PIX_W-1:PIX_W];
                got.blue    = m_axis_tdata[3*PIX_W-1:2*PIX_W];
                got.blended = m_axis_tuser;
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch("stitched pixel arrived with none expected");
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.red != want.red)
                        report_mismatch($sformatf("out_red %0d, expected %0d",
                                                  got.red, want.red));
                    if (got.green != want.green)
                        report_mismatch($sformatf("out_green %0d, expected %0d",
                                                  got.green, want.green));
                    if (got.blue != want.blue)
                        report_mismatch($sformatf("out_blue %0d, expected %0d",
                                                  got.blue, want.blue));
                    if (got.blended != want.blended)
                        report_mismatch($sformatf("was_blended %0b, expected %0b",
                                                  got.blended, want.blended));
                end
            end
            // Append the prediction at the tail of the queue.
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_pixels = {expected_pixels, stitch_pixel(s_axis_tdata)};
            end
        end
        mismatch_count <= failures;
        pending_count  <= expected_pixels.size();
    end

endmodule

### tb/sv/seam_linear_blend_test.sv
// ============================================================================
// Seam linear blend testbench
// Drives pixels through the seam blender under a series of blend windows:
// a directed set around the overlap edges, the extreme window settings and
// random windows, with bursty input and a stalling receiver. A separate
// checker predicts and compares; this module makes stimulus and decides.
// ============================================================================
`timescale 1ns / 100ps

module seam_linear_blend_test;
    import slb_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tuser;
    int                     mismatch_count;
    int                     pending_count;

    // Stimulus-side view of the window, used only to aim the columns.
    int unsigned            window_start;
    int unsigned            window_width;
    int                     burst_left;
    bit                     flood_phase;

    seam_linear_blend i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    seam_linear_blend_check i_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // 100 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("** seam_linear_blend: FAILED **");
        $finish;
    end

    function automatic pixel_t rgb(input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b);
        return {b, g, r};
    endfunction

    function automatic pixel_t random_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return pixel_t'($urandom);
        endcase
    endfunction

    // Warped pixels are black fairly often, and sometimes only just not black.
    function automatic pixel_t random_warped();
        pixel_t pix;
        pix = '0;
        case ($urandom_range(0, 9))
            0, 1:    pix = '0;
            2:       pix[$urandom_range(0, 2)] = 8'd1;
            default: pix = random_pixel();
        endcase
        return pix;
    endfunction

    // Most columns fall inside the overlap or next to its bounds.
    function automatic logic [COL_W-1:0] pick_column();
        int          limit;
        int          sel;
        int          col;
        limit = (window_width > MAX_WIDTH) ? MAX_WIDTH : int'(window_width);
        sel   = $urandom_range(0, 9);
        if (sel < 5 && int'(window_start) < limit)
        begin
            col = $urandom_range(limit - 1, window_start);
        end
        else if (sel < 7)
        begin
            col = ((sel == 5) ? int'(window_start) : limit) + int'($urandom_range(0, 2)) - 1;
            if (col < 0)
                col = 0;
            if (col > MAX_WIDTH - 1)
                col = MAX_WIDTH - 1;
        end
        else
        begin
            col = $urandom_range(0, MAX_WIDTH - 1);
        end
        return COL_W'(col);
    endfunction

    // End of a burst: drop valid for a random gap and choose the next burst.
    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Offer one pixel and hold it until the transfer.
    task automatic send_pixel(input logic [COL_W-1:0] col, input pixel_t base,
                              input pixel_t warped);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, warped, base, col};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pace_sender();
    endtask

    // Stop offering pixels until every stitched pixel has come back.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Change the blend window once the pipeline is empty. The unused top bit
    // of the overlap start word is driven at random.
    task automatic set_blend_window(input logic [START_W-1:0] start_val,
                                    input logic [WIDTH_W-1:0] width_val);
        drain_pipeline();
        write_register(REG_OVERLAP_START, {1'($urandom_range(0, 1)), start_val});
        write_register(REG_BASE_WIDTH, width_val);
        window_start = start_val;
        window_width = width_val;
    endtask

    task automatic blend_random_pixels(input logic [START_W-1:0] start_val,
                                       input logic [WIDTH_W-1:0] width_val,
                                       input int count);
        set_blend_window(start_val, width_val);
        repeat (count) send_pixel(pick_column(), random_pixel(), random_warped());
    endtask

    // Receiver: random runs and stalls, some long runs with no stall, and one
    // long hold-off while the flood phase keeps the input busy.
    initial
    begin
        int run_left;
        int stall_left;
        bit held_long;
        m_axis_tready = 1'b0;
        run_left      = 0;
        stall_left    = 0;
        held_long     = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held_long && flood_phase && s_axis_tvalid)
            begin
                held_long  = 1'b1;
                stall_left = 64;
                run_left   = 0;
            end
            if (stall_left == 0 && run_left == 0)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    run_left = $urandom_range(40, 80);
                end
                else
                begin
                    run_left   = $urandom_range(1, 12);
                    stall_left = $urandom_range(1, 5);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                run_left--;
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int unsigned rand_width;
        int unsigned rand_limit;
        int unsigned rand_start;
        int          guard;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_OVERLAP_START;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        window_start  = OVERLAP_START_RST;
        window_width  = BASE_WIDTH_RST;
        burst_left    = 8;
        flood_phase   = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset window: field extremes, width bound and black warped pixels.
        send_pixel(13'd0,    rgb(0, 0, 0),       rgb(255, 255, 255));
        send_pixel(13'd1023, rgb(255, 255, 255), rgb(1, 2, 3));
        send_pixel(13'd1024, rgb(10, 20, 30),    rgb(40, 50, 60));
        send_pixel(13'd8191, rgb(255, 0, 255),   rgb(0, 0, 0));
        send_pixel(13'd512,  rgb(200, 100, 50),  rgb(0, 0, 0));

        // Overlap narrower than its start: every overlap column blends unless its warped pixel is black.
        set_blend_window(13'd60, 14'd100);
        send_pixel(13'd59,   rgb(11, 22, 33),    rgb(44, 55, 66));
        send_pixel(13'd60,   rgb(90, 80, 70),    rgb(200, 210, 220));
        send_pixel(13'd99,   rgb(255, 255, 255), rgb(255, 255, 255));
        send_pixel(13'd99,   rgb(0, 0, 0),       rgb(255, 255, 255));
        send_pixel(13'd61,   rgb(255, 255, 255), rgb(0, 0, 1));
        send_pixel(13'd100,  rgb(1, 1, 1),       rgb(254, 253, 252));
        send_pixel(13'd80,   rgb(123, 45, 67),   rgb(0, 0, 0));
        send_pixel(13'd8191, rgb(7, 8, 9),       rgb(0, 0, 0));

        // Overlap columns at or below the overlap width copy the base pixel.
        set_blend_window(13'd10, 14'd100);
        send_pixel(13'd9,    rgb(5, 6, 7),       rgb(8, 9, 10));
        send_pixel(13'd50,   rgb(100, 150, 200), rgb(250, 30, 60));
        send_pixel(13'd95,   rgb(100, 150, 200), rgb(250, 30, 60));
        send_pixel(13'd99,   rgb(255, 0, 128),   rgb(0, 255, 128));

        // Width above the maximum saturates; only the last column overlaps.
        set_blend_window(13'd8191, 14'd16383);
        send_pixel(13'd8191, rgb(77, 88, 99),    rgb(1, 2, 3));
        send_pixel(13'd8190, rgb(77, 88, 99),    rgb(1, 2, 3));

        // Extreme windows: oversized, zero width, start beyond width and the
        // widest valid overlaps.
        blend_random_pixels(13'd8191, 14'd16383, 23);
        blend_random_pixels(13'd0,    14'd0,     25);
        blend_random_pixels(13'd500,  14'd100,   25);
        blend_random_pixels(13'd8191, 14'd8192,  25);
        blend_random_pixels(13'd0,    14'd1,     25);
        blend_random_pixels(13'd0,    14'd8192,  25);
        blend_random_pixels(13'd1,    14'd8193,  25);
        blend_random_pixels(13'd4096, 14'd8192,  25);

        // Long flood while the receiver holds off, so the input backs up.
        set_blend_window(13'd3000, 14'd6000);
        flood_phase = 1'b1;
        repeat (150) send_pixel(pick_column(), random_pixel(), random_warped());
        flood_phase = 1'b0;

        // Random windows, mostly with the start placed where blending occurs.
        repeat (8)
        begin
            rand_width = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 16383)
                                                     : $urandom_range(1, MAX_WIDTH);
            rand_limit = (rand_width > MAX_WIDTH) ? MAX_WIDTH : rand_width;
            if ($urandom_range(0, 3) == 0 || rand_limit == 0)
                rand_start = $urandom_range(0, MAX_WIDTH - 1);
            else
                rand_start = $urandom_range(rand_limit - 1, rand_limit / 3);
            blend_random_pixels(START_W'(rand_start), WIDTH_W'(rand_width), 35);
        end

        // Wait for the last results, then a little longer for strays.
        s_axis_tvalid <= 1'b0;
        guard = 0;
        @(posedge clk);
        while (pending_count != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        if (pending_count != 0)
        begin
            $display("** seam_linear_blend: FAILED **");
            $finish;
        end
        else
        begin
            repeat (20) @(posedge clk);
            if (mismatch_count == 0 && pending_count == 0)
            begin
                $display("** seam_linear_blend: PASSED **");
            end
            else
            begin
                $display("** seam_linear_blend: FAILED **");
            end
            $finish;
        end
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/slb_pkg.sv
rtl/core/slb_decode.sv
rtl/core/slb_mix.sv
rtl/core/slb_div.sv
rtl/core/seam_linear_blend.sv
rtl/core/slb_checker.sv
tb/sv/seam_linear_blend_check.sv
tb/sv/seam_linear_blend_test.sv
